// File: rtl/owt_pkg.sv
// package for the one-wire temperature reader
// phase codes, register indexes, configuration and result structs, command bytes
// no dependencies
`default_nettype none

package owt_pkg;

  localparam int CFG_W  = 20;
  localparam int TEMP_W = 16;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_REC_OK,
    PH_REC_FAIL,
    PH_WR_A,
    PH_WR_B,
    PH_CONV,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REC,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW,
    REG_PRESENCE,
    REG_RESET_REC,
    REG_WR_SHORT,
    REG_WR_LONG,
    REG_RD_LOW,
    REG_RD_REC,
    REG_CONVERT
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_RESET_LOW = CFG_W'(450);
  localparam logic [CFG_W-1:0] RST_PRESENCE  = CFG_W'(40);
  localparam logic [CFG_W-1:0] RST_RESET_REC = CFG_W'(200);
  localparam logic [CFG_W-1:0] RST_WR_SHORT  = CFG_W'(5);
  localparam logic [CFG_W-1:0] RST_WR_LONG   = CFG_W'(25);
  localparam logic [CFG_W-1:0] RST_RD_LOW    = CFG_W'(1);
  localparam logic [CFG_W-1:0] RST_RD_REC    = CFG_W'(50);
  localparam logic [CFG_W-1:0] RST_CONVERT   = CFG_W'(200000);

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  localparam logic [1:0] CMD_IDX_CONVERT = 2'd1;
  localparam logic [1:0] CMD_IDX_READ_SP = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence;
    logic [CFG_W-1:0] reset_rec;
    logic [CFG_W-1:0] wr_short;
    logic [CFG_W-1:0] wr_long;
    logic [CFG_W-1:0] rd_low;
    logic [CFG_W-1:0] rd_rec;
    logic [CFG_W-1:0] convert;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic [TEMP_W-1:0] temperature;
  } res_t;

  function automatic logic cmd_bit(logic [1:0] cmd_idx, logic [2:0] bit_idx);
    logic [7:0] cmd;
    case (cmd_idx)
      2'd0:    cmd = CMD_SKIP_ROM;
      2'd1:    cmd = CMD_CONVERT;
      2'd2:    cmd = CMD_SKIP_ROM;
      default: cmd = CMD_READ_SP;
    endcase
    return cmd[bit_idx];
  endfunction

endpackage

`default_nettype wire

// File: rtl/owt_seq.sv
// bus sequencer: phase, tick counter, bit and byte counters, read shift word
// result flags come from the current phase and temperature from the stored word; state advances by one tick per step
// depends on owt_pkg
`default_nettype none

module owt_seq #(
  parameter int TICK_COUNT_WIDTH = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          start,
  input  wire logic          bus,
  input  wire owt_pkg::cfg_t cfg,
  output owt_pkg::res_t      res
);
  import owt_pkg::*;

  localparam int CmpW = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

  phase_t                      phase, phase_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [1:0]                  command_index, command_index_next;
  logic                        read_byte_index, read_byte_index_next;
  logic [TEMP_W-1:0]           shift_word, shift_word_next;
  logic [TEMP_W-1:0]           temperature_word, temperature_word_next;

  logic [CFG_W-1:0] dur;
  logic [CFG_W-1:0] last_tick;
  logic [CmpW-1:0]  last_ext;
  logic [CmpW-1:0]  mask_ext;
  logic [CmpW-1:0]  last_sat;
  logic             timed;
  logic             ends;
  logic             cur_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      command_index    <= '0;
      read_byte_index  <= 1'b0;
      shift_word       <= '0;
      temperature_word <= '0;
    end else if (step) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      command_index    <= command_index_next;
      read_byte_index  <= read_byte_index_next;
      shift_word       <= shift_word_next;
      temperature_word <= temperature_word_next;
    end
  end

  always_comb begin
    res.drive_low   = (phase == PH_RST_LOW) || (phase == PH_WR_A) || (phase == PH_RD_LOW);
    res.busy        = (phase != PH_IDLE) && (phase != PH_DONE);
    res.done        = (phase == PH_DONE);
    res.temperature = temperature_word;
  end

  assign cur_bit = cmd_bit(command_index, bit_index);

  // phase duration, zero counts as one tick, saturated to the counter
  always_comb begin
    timed = 1'b1;
    unique case (phase)
      PH_RST_LOW:              dur = cfg.reset_low;
      PH_RST_WAIT:             dur = cfg.presence;
      PH_REC_OK, PH_REC_FAIL:  dur = cfg.reset_rec;
      PH_WR_A:                 dur = cur_bit ? cfg.wr_short : cfg.wr_long;
      PH_WR_B:                 dur = cur_bit ? cfg.wr_long : cfg.wr_short;
      PH_CONV:                 dur = cfg.convert;
      PH_RD_LOW, PH_RD_WAIT:   dur = cfg.rd_low;
      PH_RD_REC:               dur = cfg.rd_rec;
      default: begin
        dur   = '0;
        timed = 1'b0;
      end
    endcase
    last_tick = (dur == '0) ? '0 : dur - CFG_W'(1);
    last_ext  = CmpW'(last_tick);
    mask_ext  = CmpW'({TICK_COUNT_WIDTH{1'b1}});
    last_sat  = (last_ext > mask_ext) ? mask_ext : last_ext;
    ends      = CmpW'(tick_count) >= last_sat;
  end

  always_comb begin
    phase_next            = phase;
    tick_count_next       = '0;
    bit_index_next        = bit_index;
    command_index_next    = command_index;
    read_byte_index_next  = read_byte_index;
    shift_word_next       = shift_word;
    temperature_word_next = temperature_word;

    if (!timed) begin
      if (start) begin
        bit_index_next       = '0;
        command_index_next   = '0;
        read_byte_index_next = 1'b0;
        shift_word_next      = '0;
        phase_next           = PH_RST_LOW;
      end else begin
        phase_next = PH_IDLE;
      end
    end else if (!ends) begin
      tick_count_next = tick_count + TICK_COUNT_WIDTH'(1);
    end else begin
      unique case (phase)
        PH_RST_LOW:  phase_next = PH_RST_WAIT;
        PH_RST_WAIT: phase_next = bus ? PH_REC_FAIL : PH_REC_OK;
        PH_REC_FAIL: phase_next = PH_RST_LOW;
        PH_REC_OK: begin
          bit_index_next = '0;
          phase_next     = PH_WR_A;
        end
        PH_WR_A:     phase_next = PH_WR_B;
        PH_WR_B: begin
          if (bit_index != 3'd7) begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_WR_A;
          end else begin
            bit_index_next     = '0;
            command_index_next = command_index + 2'd1;
            if (command_index == CMD_IDX_CONVERT) begin
              phase_next = PH_CONV;
            end else if (command_index == CMD_IDX_READ_SP) begin
              read_byte_index_next = 1'b0;
              shift_word_next      = '0;
              phase_next           = PH_RD_LOW;
            end else begin
              phase_next = PH_WR_A;
            end
          end
        end
        PH_CONV:     phase_next = PH_RST_LOW;
        PH_RD_LOW:   phase_next = PH_RD_WAIT;
        PH_RD_WAIT: begin
          shift_word_next = {bus, shift_word[TEMP_W-1:1]};
          phase_next      = PH_RD_REC;
        end
        PH_RD_REC: begin
          if (bit_index != 3'd7) begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_RD_LOW;
          end else if (!read_byte_index) begin
            bit_index_next       = '0;
            read_byte_index_next = 1'b1;
            phase_next           = PH_RD_LOW;
          end else begin
            bit_index_next        = '0;
            read_byte_index_next  = 1'b0;
            temperature_word_next = shift_word;
            phase_next            = PH_DONE;
          end
        end
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_counters_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> bit_index == 3'd0 && !read_byte_index && command_index == 2'd0)
    else $error("counters not cleared at end of sequence");

  a_conv_after_convert_cmd: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CONV |-> command_index == 2'd2 && bit_index == 3'd0)
    else $error("conversion wait entered at wrong command");

  a_sample_shift: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_RD_WAIT && ends |=> shift_word[TEMP_W-1] == $past(bus))
    else $error("read sample not shifted in");

  a_word_on_done: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> temperature_word == shift_word)
    else $error("temperature word differs from read word");
`endif

endmodule

`default_nettype wire

// File: rtl/onewire_temp_sensor_reader.sv
// one-wire temperature reader, top level
// configuration registers, input handshake and registered result stage
// depends on owt_pkg and owt_seq
//
// usage: every request on the input channel is one bus tick carrying start_req
// and the sampled bus level; every request yields exactly one result carrying
// drive_low, busy_res, done_res and temperature as they stood during that tick.
// a result is registered and shows up on the output channel the cycle after its
// request is taken. one request is taken per clock while the output register is
// empty or being drained: the result register is the only storage between the
// channels, so sustained throughput is one tick per cycle. if the receiver
// stalls, in_ready drops and the sequencer holds its phase and counters, so bus
// timing counts only taken requests.
// configuration writes load the tick durations at once; write only while idle.
// reset clears the sequencer to idle, the temperature word to zero, empties the
// result register and loads the default durations.
`default_nettype none

module onewire_temp_sensor_reader #(
  parameter int TICK_COUNT_WIDTH = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       start_req,
  input  wire logic                       bus_level,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            drive_low,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [owt_pkg::TEMP_W-1:0]      temperature,
  input  wire logic                       cfg_wr_en,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [owt_pkg::CFG_W-1:0]  cfg_data
);
  import owt_pkg::*;

  cfg_t cfg;
  res_t seq_res;
  logic in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low <= RST_RESET_LOW;
      cfg.presence  <= RST_PRESENCE;
      cfg.reset_rec <= RST_RESET_REC;
      cfg.wr_short  <= RST_WR_SHORT;
      cfg.wr_long   <= RST_WR_LONG;
      cfg.rd_low    <= RST_RD_LOW;
      cfg.rd_rec    <= RST_RD_REC;
      cfg.convert   <= RST_CONVERT;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RESET_LOW: cfg.reset_low <= cfg_data;
        REG_PRESENCE:  cfg.presence  <= cfg_data;
        REG_RESET_REC: cfg.reset_rec <= cfg_data;
        REG_WR_SHORT:  cfg.wr_short  <= cfg_data;
        REG_WR_LONG:   cfg.wr_long   <= cfg_data;
        REG_RD_LOW:    cfg.rd_low    <= cfg_data;
        REG_RD_REC:    cfg.rd_rec    <= cfg_data;
        REG_CONVERT:   cfg.convert   <= cfg_data;
        default:       cfg.convert   <= cfg.convert;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  owt_seq #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (in_take),
    .start (start_req),
    .bus   (bus_level),
    .cfg   (cfg),
    .res   (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      drive_low   <= seq_res.drive_low;
      busy_res    <= seq_res.busy;
      done_res    <= seq_res.done;
      temperature <= seq_res.temperature;
    end
  end

`ifndef SYNTHESIS
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a result");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(busy_res && done_res) && !(drive_low && !busy_res))
    else $error("inconsistent result flags");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && done_res |=> !(out_valid && done_res))
    else $error("done held for more than one tick");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready while result register empty");
`endif

endmodule

`default_nettype wire
